/* rtl/core/rbv_pkg.sv */
package rbv_pkg;

  localparam int unsigned BAT_W   = 28;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned MV_W    = 16;
  localparam int unsigned SAT_W   = 13;
  localparam int unsigned AVG_W   = 12;
  localparam int unsigned AVGN_W  = BAT_W + 1;
  localparam int unsigned VPROD_W = BAT_W + 2 * MV_W;
  localparam int unsigned VN_W    = VPROD_W + 1;
  localparam int unsigned VDEN_W  = BAT_W + MV_W;
  localparam int unsigned QUO_W   = 17;
  localparam int unsigned CIDX_W  = 4;

  typedef enum logic [CIDX_W-1:0] {
    CFG_DIV_NUM    = 4'd0,
    CFG_DIV_DEN    = 4'd1,
    CFG_REF_NOM    = 4'd2,
    CFG_REF_SAFE   = 4'd3,
    CFG_SAT_RAW    = 4'd4,
    CFG_SUPPLY_MIN = 4'd5,
    CFG_SUPPLY_MAX = 4'd6,
    CFG_PLAUS_MAX  = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [BAT_W-1:0] battery_total;
    logic [BAT_W-1:0] reference_total;
    logic [CNT_W-1:0] count;
  } in_item_t;

  typedef struct packed {
    logic             valid_res;
    logic [AVG_W-1:0] bat_avg;
    logic [AVG_W-1:0] reference_average;
    logic [MV_W-1:0]  supply_mv;
    logic [MV_W-1:0]  bat_nom_mv;
    logic [MV_W-1:0]  bat_safe_mv;
  } out_item_t;

  typedef struct packed {
    logic [MV_W-1:0]  divider_numerator;
    logic [MV_W-1:0]  divider_denominator;
    logic [MV_W-1:0]  reference_nominal_mv;
    logic [MV_W-1:0]  reference_safety_mv;
    logic [SAT_W-1:0] saturation_raw;
    logic [MV_W-1:0]  supply_min_mv;
    logic [MV_W-1:0]  supply_max_mv;
    logic [MV_W-1:0]  plausible_max_mv;
  } cfg_t;

endpackage

/* rtl/core/rbv_queue.sv */
module rbv_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         full_o,
  output logic         empty_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end
endmodule

/* rtl/core/rbv_div.sv */
module rbv_div #(
  parameter int unsigned NW = 29,
  parameter int unsigned DW = 16,
  parameter int unsigned QB = 17
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] n_i,
  input  logic [DW-1:0] d_i,
  output logic [QB-1:0] q_o,
  output logic          ovf_o
);
  localparam int unsigned CW = (NW > DW + QB) ? NW : DW + QB;

  logic [NW-1:0] r_q [QB];
  logic [DW-1:0] d_q [QB];
  logic [QB-1:0] q_q [QB];
  logic          o_q [QB];

  // One quotient bit per stage, most significant first.
  for (genvar i = 0; i < QB; i++) begin : g_st
    localparam int unsigned B = QB - 1 - i;
    logic [NW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [QB-1:0] q_in;
    logic          o_in;
    logic [CW-1:0] trial;
    logic          take;

    if (i == 0) begin : g_first
      assign r_in = n_i;
      assign d_in = d_i;
      assign q_in = '0;
      assign o_in = CW'(n_i) >= (CW'(d_i) << QB);
    end else begin : g_next
      assign r_in = r_q[i-1];
      assign d_in = d_q[i-1];
      assign q_in = q_q[i-1];
      assign o_in = o_q[i-1];
    end

    assign trial = CW'(d_in) << B;
    assign take  = CW'(r_in) >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[i] <= take ? NW'(CW'(r_in) - trial) : r_in;
        d_q[i] <= d_in;
        q_q[i] <= q_in | (take ? (QB'(1) << B) : QB'(0));
        o_q[i] <= o_in;
      end
    end
  end

  assign q_o   = q_q[QB-1];
  assign ovf_o = o_q[QB-1];
endmodule

/* rtl/core/rbv_front.sv */
module rbv_front #(
  parameter int unsigned ADC_FULL_SCALE = 4095,
  parameter int unsigned QW             = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rbv_pkg::in_item_t in_item_i,
  input  rbv_pkg::cfg_t     cfg_i,
  input  logic              full_i,
  output logic              push_o,
  output logic [QW-1:0]     qdata_o
);
  import rbv_pkg::*;

  localparam int unsigned FSW  = $clog2(ADC_FULL_SCALE + 1);
  localparam int unsigned LW   = FSW + CNT_W;
  localparam int unsigned CMPW = (LW > BAT_W) ? LW : BAT_W;
  localparam int unsigned NFW  = MV_W + FSW;
  localparam int unsigned SUPW = NFW + CNT_W;
  localparam int unsigned SUPN = SUPW + 1;

  logic fe;
  logic v1_q, v2_q, v3_q;

  // stage 1
  logic [BAT_W-1:0]  bat1_q, ref1_q;
  logic [CNT_W-1:0]  cnt1_q;
  logic [VDEN_W-1:0] bnom1_q, bsaf1_q, vden1_q;
  logic [NFW-1:0]    nomfs1_q;
  logic [LW-1:0]     lim1_q;
  logic              bad1_q;
  // stage 2
  logic [BAT_W-1:0]   bat2_q, ref2_q;
  logic [CNT_W-1:0]   cnt2_q;
  logic [VPROD_W-1:0] vn2_q, sn2_q;
  logic [VDEN_W-1:0]  vden2_q;
  logic [SUPW-1:0]    supn2_q;
  logic               bad2_q;
  // stage 3
  logic               bad3_q;
  logic [AVGN_W-1:0]  navb3_q, navr3_q;
  logic [CNT_W-1:0]   cnt3_q;
  logic [SUPN-1:0]    nsup3_q;
  logic [BAT_W-1:0]   ref3_q;
  logic [VN_W-1:0]    nv3_q, ns3_q;
  logic [VDEN_W-1:0]  vden3_q;

  // advance unless the last stage holds an item the queue cannot take
  assign fe         = !(v3_q && full_i);
  assign in_ready_o = fe;
  assign push_o     = v3_q && !full_i;
  assign qdata_o    = {bad3_q, navb3_q, navr3_q, cnt3_q, nsup3_q, ref3_q,
                       nv3_q, ns3_q, vden3_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (fe) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fe) begin
      bat1_q   <= in_item_i.battery_total;
      ref1_q   <= in_item_i.reference_total;
      cnt1_q   <= in_item_i.count;
      bnom1_q  <= VDEN_W'(in_item_i.battery_total) * VDEN_W'(cfg_i.reference_nominal_mv);
      bsaf1_q  <= VDEN_W'(in_item_i.battery_total) * VDEN_W'(cfg_i.reference_safety_mv);
      vden1_q  <= VDEN_W'(in_item_i.reference_total) * VDEN_W'(cfg_i.divider_denominator);
      nomfs1_q <= NFW'(cfg_i.reference_nominal_mv) * NFW'(ADC_FULL_SCALE);
      lim1_q   <= LW'(in_item_i.count) * LW'(ADC_FULL_SCALE);
      bad1_q   <= (in_item_i.count == '0) || (in_item_i.reference_total == '0) ||
                  (cfg_i.divider_denominator == '0);

      bat2_q  <= bat1_q;
      ref2_q  <= ref1_q;
      cnt2_q  <= cnt1_q;
      vn2_q   <= VPROD_W'(bnom1_q) * VPROD_W'(cfg_i.divider_numerator);
      sn2_q   <= VPROD_W'(bsaf1_q) * VPROD_W'(cfg_i.divider_numerator);
      vden2_q <= vden1_q;
      supn2_q <= SUPW'(nomfs1_q) * SUPW'(cnt1_q);
      bad2_q  <= bad1_q || (CMPW'(bat1_q) > CMPW'(lim1_q)) ||
                 (CMPW'(ref1_q) > CMPW'(lim1_q));

      // add half the divisor for round-half-up
      bad3_q  <= bad2_q;
      navb3_q <= AVGN_W'(bat2_q) + AVGN_W'(cnt2_q >> 1);
      navr3_q <= AVGN_W'(ref2_q) + AVGN_W'(cnt2_q >> 1);
      cnt3_q  <= cnt2_q;
      nsup3_q <= SUPN'(supn2_q) + SUPN'(ref2_q >> 1);
      ref3_q  <= ref2_q;
      nv3_q   <= VN_W'(vn2_q) + VN_W'(vden2_q >> 1);
      ns3_q   <= VN_W'(sn2_q) + VN_W'(vden2_q >> 1);
      vden3_q <= vden2_q;
    end
  end
endmodule

/* rtl/core/rbv_back.sv */
module rbv_back #(
  parameter int unsigned ADC_FULL_SCALE = 4095,
  parameter int unsigned QW             = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [QW-1:0]      qdata_i,
  input  logic               empty_i,
  output logic               pop_o,
  input  rbv_pkg::cfg_t      cfg_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rbv_pkg::out_item_t out_item_o
);
  import rbv_pkg::*;

  localparam int unsigned FSW  = $clog2(ADC_FULL_SCALE + 1);
  localparam int unsigned SUPN = MV_W + FSW + CNT_W + 1;

  logic               adv;
  logic               bad;
  logic [AVGN_W-1:0]  navb, navr;
  logic [CNT_W-1:0]   cnt;
  logic [SUPN-1:0]    nsup;
  logic [BAT_W-1:0]   ref_tot;
  logic [VN_W-1:0]    nv, ns;
  logic [VDEN_W-1:0]  vden;

  logic [QUO_W-1:0] bq, rq, sq, vq, svq;
  logic             bo, ro, so, vo, svo;
  logic [QUO_W-1:0] v_q, bad_q;
  logic             ok;
  out_item_t        res, out_q;
  logic             out_v_q;

  assign {bad, navb, navr, cnt, nsup, ref_tot, nv, ns, vden} = qdata_i;

  // the whole back pipe stalls only while a finished item waits at the output
  assign adv   = !out_v_q || out_ready_i;
  assign pop_o = adv && !empty_i;

  rbv_div #(.NW(AVGN_W), .DW(CNT_W), .QB(QUO_W)) u_div_bat (
    .clk_i, .en_i(adv), .n_i(navb), .d_i(cnt), .q_o(bq), .ovf_o(bo));
  rbv_div #(.NW(AVGN_W), .DW(CNT_W), .QB(QUO_W)) u_div_ref (
    .clk_i, .en_i(adv), .n_i(navr), .d_i(cnt), .q_o(rq), .ovf_o(ro));
  rbv_div #(.NW(SUPN), .DW(BAT_W), .QB(QUO_W)) u_div_sup (
    .clk_i, .en_i(adv), .n_i(nsup), .d_i(ref_tot), .q_o(sq), .ovf_o(so));
  rbv_div #(.NW(VN_W), .DW(VDEN_W), .QB(QUO_W)) u_div_volt (
    .clk_i, .en_i(adv), .n_i(nv), .d_i(vden), .q_o(vq), .ovf_o(vo));
  rbv_div #(.NW(VN_W), .DW(VDEN_W), .QB(QUO_W)) u_div_safe (
    .clk_i, .en_i(adv), .n_i(ns), .d_i(vden), .q_o(svq), .ovf_o(svo));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      v_q     <= {v_q[QUO_W-2:0], pop_o};
      out_v_q <= v_q[QUO_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bad_q <= {bad_q[QUO_W-2:0], bad};
      out_q <= res;
    end
  end

  always_comb begin
    ok = !bad_q[QUO_W-1] && !bo && !ro && !so && !vo && !svo &&
         (bq < QUO_W'(cfg_i.saturation_raw)) && (bq[QUO_W-1:AVG_W] == '0) &&
         (rq != '0) && (rq < QUO_W'(cfg_i.saturation_raw)) &&
         (rq[QUO_W-1:AVG_W] == '0) &&
         (sq >= QUO_W'(cfg_i.supply_min_mv)) && (sq <= QUO_W'(cfg_i.supply_max_mv)) &&
         (vq <= QUO_W'(cfg_i.plausible_max_mv)) &&
         (vq[QUO_W-1:MV_W] == '0) && (svq[QUO_W-1:MV_W] == '0);
    res = '0;
    if (ok) begin
      res.valid_res         = 1'b1;
      res.bat_avg           = bq[AVG_W-1:0];
      res.reference_average = rq[AVG_W-1:0];
      res.supply_mv         = sq[MV_W-1:0];
      res.bat_nom_mv        = vq[MV_W-1:0];
      res.bat_safe_mv       = svq[MV_W-1:0];
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;
endmodule

/* rtl/core/ratiometric_battery_voltage_unit.sv */
// Path from input accept to result valid at the output register: the accepting
// edge loads the first of 3 front stages, then 1 queue slot, 17 divider
// stages, 1 output register.
// Throughput: one item per cycle absent output back-pressure; the 17-stage
// restoring dividers retire one quotient bit per stage, advancing with the pipe.
// Reset (rst_ni low, asynchronous): pipeline and queue empty, config registers
// return to their default values.
module ratiometric_battery_voltage_unit #(
  parameter int unsigned ADC_FULL_SCALE = 4095
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  rbv_pkg::in_item_t                   in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output rbv_pkg::out_item_t                  out_item_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rbv_pkg::CIDX_W-1:0]          cfg_index_i,
  input  logic [rbv_pkg::MV_W-1:0]            cfg_data_i
);
  import rbv_pkg::*;

  localparam int unsigned FSW   = $clog2(ADC_FULL_SCALE + 1);
  localparam int unsigned SUPN  = MV_W + FSW + CNT_W + 1;
  // queue item: reject flag, rounded dividends and their divisors
  localparam int unsigned QW    = 1 + 2 * AVGN_W + CNT_W + SUPN + BAT_W +
                                  2 * VN_W + VDEN_W;
  localparam int unsigned QDEPTH = 4;

  cfg_t          cfg_q;
  logic          push, pop, full, empty;
  logic [QW-1:0] wdata, rdata;

  // Config writes are registered; the port never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.divider_numerator    <= MV_W'(2);
      cfg_q.divider_denominator  <= MV_W'(1);
      cfg_q.reference_nominal_mv <= MV_W'(1212);
      cfg_q.reference_safety_mv  <= MV_W'(1180);
      cfg_q.saturation_raw       <= SAT_W'(4095);
      cfg_q.supply_min_mv        <= MV_W'(1800);
      cfg_q.supply_max_mv        <= MV_W'(3600);
      cfg_q.plausible_max_mv     <= MV_W'(20000);
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DIV_NUM:    cfg_q.divider_numerator    <= cfg_data_i;
        CFG_DIV_DEN:    cfg_q.divider_denominator  <= cfg_data_i;
        CFG_REF_NOM:    cfg_q.reference_nominal_mv <= cfg_data_i;
        CFG_REF_SAFE:   cfg_q.reference_safety_mv  <= cfg_data_i;
        CFG_SAT_RAW:    cfg_q.saturation_raw       <= cfg_data_i[SAT_W-1:0];
        CFG_SUPPLY_MIN: cfg_q.supply_min_mv        <= cfg_data_i;
        CFG_SUPPLY_MAX: cfg_q.supply_max_mv        <= cfg_data_i;
        CFG_PLAUS_MAX:  cfg_q.plausible_max_mv     <= cfg_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Front: accept the item, form products, range checks and rounded dividends.
  rbv_front #(.ADC_FULL_SCALE(ADC_FULL_SCALE), .QW(QW)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_item_i,
    .cfg_i   (cfg_q),
    .full_i  (full),
    .push_o  (push),
    .qdata_o (wdata)
  );

  // Queue: decouple front stalls from output back-pressure.
  rbv_queue #(.W(QW), .DEPTH(QDEPTH)) u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .wdata_i (wdata),
    .pop_i   (pop),
    .rdata_o (rdata),
    .full_o  (full),
    .empty_o (empty)
  );

  // Back: pipelined dividers, final window checks, output register.
  rbv_back #(.ADC_FULL_SCALE(ADC_FULL_SCALE), .QW(QW)) u_back (
    .clk_i, .rst_ni,
    .qdata_i (rdata),
    .empty_i (empty),
    .pop_o   (pop),
    .cfg_i   (cfg_q),
    .out_valid_o, .out_ready_i, .out_item_o
  );
endmodule

/* rtl/core/rbv_checker.sv */
module rbv_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input rbv_pkg::out_item_t out_item_o
);
  import rbv_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("result changed while stalled");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.valid_res |->
      out_item_o.bat_avg == '0 && out_item_o.reference_average == '0 &&
      out_item_o.supply_mv == '0 && out_item_o.bat_nom_mv == '0 &&
      out_item_o.bat_safe_mv == '0)
    else $error("rejected item carries nonzero fields");

  a_ref_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.valid_res |-> out_item_o.reference_average != '0)
    else $error("accepted item with zero reference average");

  a_quiet_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result offered during reset");
endmodule

bind ratiometric_battery_voltage_unit rbv_checker u_rbv_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .out_item_o
);

/* sim/rbv_result_checker.sv */
`timescale 1ns / 100ps

module rbv_result_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  rbv_pkg::in_item_t          in_item_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  rbv_pkg::out_item_t         out_item_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [rbv_pkg::CIDX_W-1:0] cfg_index_i,
  input  logic [rbv_pkg::MV_W-1:0]   cfg_data_i,
  output int unsigned                mismatch_count_o,
  output int unsigned                outstanding_o
);
  import rbv_pkg::*;

  localparam longint unsigned FULL_SCALE = 4095;

  cfg_t      regs_q;
  out_item_t due_results[$];

  function automatic longint unsigned div_half_up(longint unsigned n, longint unsigned d);
    return (n + d / 2) / d;
  endfunction

  function automatic out_item_t convert_sums(in_item_t it, cfg_t c);
    out_item_t       r;
    longint unsigned bat, rsum, cnt, lim, bavg, ravg, sup, vden, volt, svolt;
    r    = '0;
    bat  = it.battery_total;
    rsum = it.reference_total;
    cnt  = it.count;
    if (cnt == 0 || rsum == 0 || c.divider_denominator == 0) return r;
    lim = FULL_SCALE * cnt;
    if (bat > lim || rsum > lim) return r;
    bavg = div_half_up(bat, cnt);
    ravg = div_half_up(rsum, cnt);
    if (bavg >= c.saturation_raw || bavg > 4095 || ravg == 0 ||
        ravg >= c.saturation_raw || ravg > 4095) return r;
    sup   = div_half_up(longint'(c.reference_nominal_mv) * FULL_SCALE * cnt, rsum);
    vden  = rsum * c.divider_denominator;
    volt  = div_half_up(bat * c.reference_nominal_mv * c.divider_numerator, vden);
    svolt = div_half_up(bat * c.reference_safety_mv * c.divider_numerator, vden);
    if (sup < c.supply_min_mv || sup > c.supply_max_mv || volt > c.plausible_max_mv ||
        volt > 16'hFFFF || svolt > 16'hFFFF) return r;
    r.valid_res         = 1'b1;
    r.bat_avg           = bavg[AVG_W-1:0];
    r.reference_average = ravg[AVG_W-1:0];
    r.supply_mv         = sup[MV_W-1:0];
    r.bat_nom_mv        = volt[MV_W-1:0];
    r.bat_safe_mv       = svolt[MV_W-1:0];
    return r;
  endfunction

  assign outstanding_o = due_results.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      regs_q <= '{divider_numerator: 16'd2, divider_denominator: 16'd1,
                  reference_nominal_mv: 16'd1212, reference_safety_mv: 16'd1180,
                  saturation_raw: 13'd4095, supply_min_mv: 16'd1800,
                  supply_max_mv: 16'd3600, plausible_max_mv: 16'd20000};
      mismatch_count_o <= 0;
      due_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_DIV_NUM:    regs_q.divider_numerator    <= cfg_data_i;
          CFG_DIV_DEN:    regs_q.divider_denominator  <= cfg_data_i;
          CFG_REF_NOM:    regs_q.reference_nominal_mv <= cfg_data_i;
          CFG_REF_SAFE:   regs_q.reference_safety_mv  <= cfg_data_i;
          CFG_SAT_RAW:    regs_q.saturation_raw       <= cfg_data_i[SAT_W-1:0];
          CFG_SUPPLY_MIN: regs_q.supply_min_mv        <= cfg_data_i;
          CFG_SUPPLY_MAX: regs_q.supply_max_mv        <= cfg_data_i;
          CFG_PLAUS_MAX:  regs_q.plausible_max_mv     <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) due_results.push_back(convert_sums(in_item_i, regs_q));
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          if (mismatch_count_o < 10) $display("unexpected result %p", out_item_i);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          want = due_results.pop_front();
          if (want !== out_item_i) begin
            if (mismatch_count_o < 10)
              $display("result mismatch: expected %p, got %p", want, out_item_i);
            mismatch_count_o <= mismatch_count_o + 1;
          end
        end
      end
    end
  end

endmodule

/* sim/tb_ratiometric_battery_voltage_unit.sv */
`timescale 1ns / 100ps

module tb_ratiometric_battery_voltage_unit;
  import rbv_pkg::*;

  // index past the register list; the block must ignore it
  localparam logic [CIDX_W-1:0] CFG_UNUSED = 4'd12;
  localparam int               DRAIN_CYCLES = 30;  // idle margin after the last result has been taken

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CIDX_W-1:0]     cfg_index;
  logic [MV_W-1:0]       cfg_data;
  int unsigned           mismatches;
  int unsigned           outstanding;
  int unsigned           send_idle_pct;
  int unsigned           recv_idle_pct;

  ratiometric_battery_voltage_unit u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_item_o(out_item),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  rbv_result_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_item_i(in_item),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_item_i(out_item),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .mismatch_count_o(mismatches), .outstanding_o(outstanding)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Generous cap on simulation time.
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver: hold off for a long stretch right after reset so the pipeline
  // fills and backs up into the input, then stall at the current rate.
  initial begin
    int unsigned held;
    out_ready = 1'b0;
    @(posedge clk);
    wait (rst_n);
    for (held = 0; held < 300; held++) @(posedge clk);
    forever begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      @(posedge clk);
    end
  end

  // Offer one item; optionally insert a single idle cycle first.
  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [MV_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t mk_item(longint unsigned bat, longint unsigned rsum,
                                       longint unsigned cnt);
    in_item_t it;
    it.battery_total   = bat[BAT_W-1:0];
    it.reference_total = rsum[BAT_W-1:0];
    it.count           = cnt[CNT_W-1:0];
    return it;
  endfunction

  // Mostly well-formed sums built from an average and a count, the rest noise.
  function automatic in_item_t random_item();
    longint unsigned cnt, bavg, ravg;
    int unsigned     sel;
    sel = $urandom_range(99);
    if (sel < 10) return mk_item($urandom, $urandom, $urandom);
    sel = $urandom_range(99);
    if (sel < 60)      cnt = $urandom_range(64, 1);
    else if (sel < 85) cnt = $urandom_range(4095, 1);
    else               cnt = $urandom_range(65535, 1);
    bavg = $urandom_range(4095);
    // land the reference average near where the supply falls inside its window
    ravg = ($urandom_range(1)) ? $urandom_range(2900, 1300) : $urandom_range(4095, 1);
    return mk_item(bavg * cnt + $urandom_range(32'(cnt - 1)),
                   ravg * cnt + $urandom_range(32'(cnt - 1)), cnt);
  endfunction

  task automatic load_config(logic [MV_W-1:0] num, logic [MV_W-1:0] den,
                             logic [MV_W-1:0] nom, logic [MV_W-1:0] safe,
                             logic [MV_W-1:0] sat, logic [MV_W-1:0] smin,
                             logic [MV_W-1:0] smax, logic [MV_W-1:0] plaus);
    // drop valid, drain all results, then let the pipeline empty
    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(CFG_DIV_NUM, num);
    write_reg(CFG_DIV_DEN, den);
    write_reg(CFG_REF_NOM, nom);
    write_reg(CFG_REF_SAFE, safe);
    write_reg(CFG_SAT_RAW, sat);
    write_reg(CFG_SUPPLY_MIN, smin);
    write_reg(CFG_SUPPLY_MAX, smax);
    write_reg(CFG_PLAUS_MAX, plaus);
    write_reg(CFG_UNUSED, MV_W'($urandom));
  endtask

  initial begin
    int n;
    int phase;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_item       = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    send_idle_pct = 33;
    recv_idle_pct = 59;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items at reset register values.
    send_item(mk_item(1000, 1000, 0));                  // zero count
    send_item(mk_item(2000, 0, 1));                     // zero reference sum
    send_item(mk_item(4096 * 4, 2000 * 4, 4));          // battery sum above full scale
    send_item(mk_item(2000 * 4, 4096 * 4, 4));          // reference sum above full scale
    send_item(mk_item(4095 * 65535, 2000 * 65535, 65535)); // battery average saturated
    send_item(mk_item(2000, 4095, 1));                  // reference average saturated
    send_item(mk_item(1000, 1, 3));                     // reference average rounds to zero
    send_item(mk_item(2000 * 16, 2000 * 16 + 8, 16));   // ordinary reading, rounds up
    send_item(mk_item(2000 * 16, 2000 * 16 + 7, 16));   // just below the half
    send_item(mk_item(1500, 1380, 1));                  // supply near upper edge
    send_item(mk_item(1500, 4000, 1));                  // supply too low
    send_item(mk_item(1500, 1000, 1));                  // supply too high
    send_item(mk_item(4094, 1500, 1));                  // battery average just below saturation
    send_item(mk_item(0, 2000, 1));                     // zero battery
    send_item(mk_item(0, 0, 0));
    send_item(mk_item(28'hFFFFFFF, 28'hFFFFFFF, 16'hFFFF));
    send_item(mk_item(4094 * 65535, 2000 * 65535, 65535));
    send_item(mk_item(3000 * 300, 2200 * 300, 300));

    // Random phases; idling: sender 33 / receiver 59, then swapped, then none.
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        1: load_config(16'd1, 16'd1, 16'd1212, 16'd1180, 16'd4096, 16'd0, 16'hFFFF, 16'hFFFF);
        2: load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd8191, 16'd0, 16'hFFFF,
                       16'hFFFF);
        3: load_config(16'd11, 16'd3, 16'd1, 16'd1, 16'd1, 16'hFFFF, 16'd0, 16'd0);
        4: load_config(16'd3, 16'd0, 16'd1212, 16'd1180, 16'd4095, 16'd1800, 16'd3600,
                       16'd20000);
        5: load_config(16'd7, 16'd2, 16'd1200, 16'd1150, 16'd4000, 16'd1700, 16'd3700,
                       16'd30000);
        default: ;
      endcase
      send_idle_pct = (phase < 2) ? 33 : (phase < 4) ? 59 : 0;
      recv_idle_pct = (phase < 2) ? 59 : (phase < 4) ? 33 : 0;
      for (n = 0; n < 190; n++) send_item(random_item());
    end
    in_valid <= 1'b0;

    // Let everything drain, then give the verdict.
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/rbv_pkg.sv
rtl/core/rbv_queue.sv
rtl/core/rbv_div.sv
rtl/core/rbv_front.sv
rtl/core/rbv_back.sv
rtl/core/ratiometric_battery_voltage_unit.sv
rtl/core/rbv_checker.sv
sim/rbv_result_checker.sv
sim/tb_ratiometric_battery_voltage_unit.sv
